// ----- design/sha256_pkg.sv -----
// Shared types and constants for the SHA-256 message digest block.
package sha256_pkg;

   localparam int BLOCK_WORDS = 16;
   localparam int HASH_WORDS  = 8;
   localparam int ROUNDS      = 64;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0]  PAD_MARKER  = 8'h80;
   localparam logic [63:0] BITS_PER_BYTE = 64'd8;

   // Block as sixteen big-endian words, word 0 first.
   typedef logic [0:BLOCK_WORDS-1][31:0] block_type;

   // One unit of work for the compression side.
   typedef struct packed {
      block_type words;
      logic      last_block;   // emit the digest after this block
   } job_type;

   localparam logic [31:0] INIT_HASH [HASH_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

// ----- design/sha256_front.sv -----
// Front end: packs message bytes into blocks and builds the padding blocks.
module sha256_front
   import sha256_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_msg_byte,
   input  logic       req_byte_present,
   input  logic       req_last_of_message,
   output logic       push_valid,
   output job_type    push_job,
   input  logic       queue_full
);

   typedef enum logic [1:0] {
      F_ACCEPT,
      F_PAD_MAIN,
      F_PAD_EXTRA
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [5:0]      fill_ff, fill_in;
   logic [63:0]     count_ff, count_in;
   block_type       stage_ff, stage_in;

   block_type merged;
   block_type padded;
   block_type length_blk;
   logic      accept;
   logic      two_blocks;

   assign req_ready  = (state_ff == F_ACCEPT) && !queue_full;
   assign accept     = req_valid && req_ready;
   // No room for the length in this block once 56 bytes are in
   assign two_blocks = (fill_ff[5:3] == 3'b111);

   // Stage with the incoming byte placed big-endian
   always_comb begin
      merged = stage_ff;
      merged[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] = req_msg_byte;
   end

   // Padding: keep bytes below fill, marker at fill, zeros above, length at end if it fits
   always_comb begin
      logic [5:0] pos;
      padded = '0;
      for (int p = 0; p < 64; p++) begin
         pos = 6'(p);
         if (pos < fill_ff) begin
            padded[pos[5:2]][{~pos[1:0], 3'b000} +: 8] =
               stage_ff[pos[5:2]][{~pos[1:0], 3'b000} +: 8];
         end else if (pos == fill_ff) begin
            padded[pos[5:2]][{~pos[1:0], 3'b000} +: 8] = PAD_MARKER;
         end
      end
      if (!two_blocks) begin
         padded[BLOCK_WORDS-2] = count_ff[63:32];
         padded[BLOCK_WORDS-1] = count_ff[31:0];
      end
   end

   // Extra block that carries only the length
   always_comb begin
      length_blk = '0;
      length_blk[BLOCK_WORDS-2] = count_ff[63:32];
      length_blk[BLOCK_WORDS-1] = count_ff[31:0];
   end

   // Next state and queue pushes
   always_comb begin
      state_in            = state_ff;
      fill_in             = fill_ff;
      count_in            = count_ff;
      stage_in            = stage_ff;
      push_valid          = 1'b0;
      push_job.words      = merged;
      push_job.last_block = 1'b0;
      case (state_ff)
         F_ACCEPT: begin
            if (accept) begin
               if (req_byte_present) begin
                  stage_in = merged;
                  fill_in  = fill_ff + 6'd1;
                  count_in = count_ff + BITS_PER_BYTE;
                  if (fill_ff == 6'd63) begin
                     push_valid = 1'b1;
                  end
               end
               if (req_last_of_message) begin
                  state_in = F_PAD_MAIN;
               end
            end
         end
         F_PAD_MAIN: begin
            push_job.words      = padded;
            push_job.last_block = !two_blocks;
            if (!queue_full) begin
               push_valid = 1'b1;
               if (two_blocks) begin
                  state_in = F_PAD_EXTRA;
               end else begin
                  state_in = F_ACCEPT;
                  fill_in  = '0;
                  count_in = '0;
               end
            end
         end
         F_PAD_EXTRA: begin
            push_job.words      = length_blk;
            push_job.last_block = 1'b1;
            if (!queue_full) begin
               push_valid = 1'b1;
               state_in   = F_ACCEPT;
               fill_in    = '0;
               count_in   = '0;
            end
         end
         default: begin
            state_in = F_ACCEPT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      if (reset) begin
         state_ff <= F_ACCEPT;
         fill_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- design/sha256_queue.sv -----
// Short block queue between the front end and the compression engine.
module sha256_queue
   import sha256_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  job_type push_job,
   output logic    queue_full,
   output logic    pop_valid,
   output job_type pop_job,
   input  logic    pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push, do_pop;

   assign queue_full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !queue_full;
   assign do_pop     = pop && pop_valid;

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- design/sha256_back.sv -----
// Compression engine: one SHA-256 round per cycle, then digest word output.
module sha256_back
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        pop_valid,
   input  job_type     pop_job,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   typedef enum logic [1:0] {
      B_IDLE,
      B_ROUND,
      B_ADD,
      B_OUTPUT
   } back_state_type;

   back_state_type state_ff;
   logic [5:0]     round_ff;
   logic           last_ff;
   logic [2:0]     out_idx_ff;
   logic           rsp_valid_ff;
   logic [31:0]    chain_ff [HASH_WORDS];
   logic [31:0]    vars_ff  [HASH_WORDS];
   block_type      win_ff;

   logic [31:0] big1, big0, ch, maj, t1, t2, next_w;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Round datapath; win_ff[k] holds W[t+k]
   always_comb begin
      big1   = rotr(vars_ff[4], 6) ^ rotr(vars_ff[4], 11) ^ rotr(vars_ff[4], 25);
      ch     = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
      t1     = vars_ff[7] + big1 + ch + ROUND_K[round_ff] + win_ff[0];
      big0   = rotr(vars_ff[0], 2) ^ rotr(vars_ff[0], 13) ^ rotr(vars_ff[0], 22);
      maj    = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
             ^ (vars_ff[1] & vars_ff[2]);
      t2     = big0 + maj;
      next_w = (rotr(win_ff[14], 17) ^ rotr(win_ff[14], 19) ^ (win_ff[14] >> 10))
             + win_ff[9]
             + (rotr(win_ff[1], 7) ^ rotr(win_ff[1], 18) ^ (win_ff[1] >> 3))
             + win_ff[0];
   end

   assign pop             = (state_ff == B_IDLE) && pop_valid;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_word = chain_ff[out_idx_ff];
   assign rsp_word_index  = out_idx_ff;
   assign rsp_last_word   = (out_idx_ff == 3'(HASH_WORDS - 1));

   // Sequencer, working variables, schedule window and chaining hash
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         round_ff     <= '0;
         last_ff      <= 1'b0;
         out_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < HASH_WORDS; i++) begin
            chain_ff[i] <= INIT_HASH[i];
         end
      end else begin
         case (state_ff)
            B_IDLE: begin
               if (pop_valid) begin
                  win_ff   <= pop_job.words;
                  last_ff  <= pop_job.last_block;
                  round_ff <= '0;
                  for (int i = 0; i < HASH_WORDS; i++) begin
                     vars_ff[i] <= chain_ff[i];
                  end
                  state_ff <= B_ROUND;
               end
            end
            B_ROUND: begin
               vars_ff[0] <= t1 + t2;
               vars_ff[1] <= vars_ff[0];
               vars_ff[2] <= vars_ff[1];
               vars_ff[3] <= vars_ff[2];
               vars_ff[4] <= vars_ff[3] + t1;
               vars_ff[5] <= vars_ff[4];
               vars_ff[6] <= vars_ff[5];
               vars_ff[7] <= vars_ff[6];
               for (int k = 0; k < BLOCK_WORDS - 1; k++) begin
                  win_ff[k] <= win_ff[k+1];
               end
               win_ff[BLOCK_WORDS-1] <= next_w;
               round_ff <= round_ff + 6'd1;
               if (round_ff == 6'(ROUNDS - 1)) begin
                  state_ff <= B_ADD;
               end
            end
            B_ADD: begin
               for (int i = 0; i < HASH_WORDS; i++) begin
                  chain_ff[i] <= chain_ff[i] + vars_ff[i];
               end
               if (last_ff) begin
                  out_idx_ff   <= '0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= B_OUTPUT;
               end else begin
                  state_ff <= B_IDLE;
               end
            end
            B_OUTPUT: begin
               if (rsp_ready) begin
                  if (out_idx_ff == 3'(HASH_WORDS - 1)) begin
                     rsp_valid_ff <= 1'b0;
                     out_idx_ff   <= '0;
                     for (int i = 0; i < HASH_WORDS; i++) begin
                        chain_ff[i] <= INIT_HASH[i];
                     end
                     state_ff <= B_IDLE;
                  end else begin
                     out_idx_ff <= out_idx_ff + 3'd1;
                  end
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- design/sha256_message_digest.sv -----
// SHA-256 digest of a byte stream. The front end takes one byte per cycle and
// packs it into a 64-byte block; a two-block queue hands full and padding
// blocks to the compression engine, which runs one round per cycle. Each block
// takes the engine through load, 64 rounds and hash update, so a long message
// streams at a rate set by the round loop. The front end stalls when both queue
// slots hold blocks, and after the end mark while it writes the padding blocks.
// The item marked last_of_message adds one or two padding blocks (two when 56
// or more bytes of the final block are in use); after the last block the eight
// digest words come out in order, H0 first, one per accepted cycle, and the
// hash returns to its initial values. An item with no byte and no end mark has
// no effect.
module sha256_message_digest
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_byte_present,
   input  logic        req_last_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   logic    push_valid;
   job_type push_job;
   logic    queue_full;
   logic    pop_valid;
   job_type pop_job;
   logic    pop;

   sha256_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_msg_byte        (req_msg_byte),
      .req_byte_present    (req_byte_present),
      .req_last_of_message (req_last_of_message),
      .push_valid          (push_valid),
      .push_job            (push_job),
      .queue_full          (queue_full)
   );

   sha256_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .queue_full (queue_full),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop        (pop)
   );

   sha256_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_job         (pop_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

endmodule

// ----- design/sha256_checker.sv -----
// Port-level checks for the SHA-256 digest block, bound to the top level.
module sha256_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);

   // A stalled result item holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_digest_word) && $stable(rsp_word_index))
      else $error("result item changed while stalled");

   // Last flag marks exactly the eighth word
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7)))
      else $error("last_word does not match word index");

   // Digest words leave back to back, index counting up
   a_word_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_word |=>
         rsp_valid && (rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest word sequence broken");

   // Nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sha256_message_digest sha256_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_digest_word (rsp_digest_word),
   .rsp_word_index  (rsp_word_index),
   .rsp_last_word   (rsp_last_word)
);

// ----- dv/sha256_message_digest_tb.sv -----
// Self-checking testbench for the byte-serial SHA-256 message digest block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 300;
   localparam int REPORT_MAX   = 10;

   // Round constants and initial hash, kept separate from the design's copy
   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] SHA_H0 [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   logic        clock               = 1'b0;
   logic        reset               = 1'b1;
   logic        req_valid           = 1'b0;
   logic        req_ready;
   logic [7:0]  req_msg_byte        = 8'h00;
   logic        req_byte_present    = 1'b0;
   logic        req_last_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready           = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   // Predictor state: block under construction, chaining hash, length
   logic [31:0] msg_block [16];
   logic [31:0] chain_hash [8] = SHA_H0;
   logic [63:0] msg_bit_len    = '0;
   logic [5:0]  fill_pos       = '0;

   digest_word_type digest_queue [$];
   digest_word_type oldest;

   int send_idle_pct   = 0;
   int recv_idle_pct   = 0;
   int items_sent      = 0;
   int bytes_hashed    = 0;
   int messages_hashed = 0;
   int words_checked   = 0;
   int mismatch_count  = 0;
   int cycle_count     = 0;

   sha256_message_digest u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_msg_byte        (req_msg_byte),
      .req_byte_present    (req_byte_present),
      .req_last_of_message (req_last_of_message),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_digest_word     (rsp_digest_word),
      .rsp_word_index      (rsp_word_index),
      .rsp_last_word       (rsp_last_word)
   );

   always #1 clock = ~clock;

   function automatic logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // One 64-round compression of msg_block into chain_hash
   function automatic void sha_compress();
      logic [31:0] v [8];
      logic [31:0] w [16];
      logic [31:0] wt, s0, s1, t1, t2, e, a, w15, w2;
      w = msg_block;
      v = chain_hash;
      for (int t = 0; t < 64; t++) begin
         if (t < 16) begin
            wt = w[t];
         end else begin
            w15 = w[(t - 15) & 15];
            w2  = w[(t - 2) & 15];
            s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
            s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
            wt  = w[t & 15] + s0 + w[(t - 7) & 15] + s1;
            w[t & 15] = wt;
         end
         e  = v[4];
         a  = v[0];
         t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
              + ((e & v[5]) ^ (~e & v[6])) + SHA_K[t] + wt;
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
              + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain_hash[i] += v[i];
   endfunction

   // Big-endian byte placement; the first byte of a word clears the rest
   function automatic void sha_place_byte(int pos, logic [7:0] b);
      logic [31:0] val;
      val = 32'(b) << ((3 - (pos & 3)) * 8);
      if ((pos & 3) == 0) msg_block[pos >> 2] = val;
      else msg_block[pos >> 2] |= val;
   endfunction

   // Absorb one accepted item; on the end mark, pad and queue the digest
   function automatic void sha_absorb_item(logic [7:0] b, logic present, logic last);
      digest_word_type dw;
      if (present) begin
         sha_place_byte(fill_pos, b);
         msg_bit_len += 64'd8;
         fill_pos    += 6'd1;
         bytes_hashed++;
         if (fill_pos == 6'd0) sha_compress();
      end
      if (!last) return;
      sha_place_byte(fill_pos, PAD_BYTE);
      for (int p = int'(fill_pos) + 1; p < 64; p++) sha_place_byte(p, 8'h00);
      // no room for the length: spill into a second padding block
      if (fill_pos >= 6'd56) begin
         sha_compress();
         for (int i = 0; i < 16; i++) msg_block[i] = '0;
      end
      msg_block[14] = msg_bit_len[63:32];
      msg_block[15] = msg_bit_len[31:0];
      sha_compress();
      for (int i = 0; i < 8; i++) begin
         dw.word  = chain_hash[i];
         dw.index = 3'(i);
         dw.last  = (i == 7);
         digest_queue.insert(digest_queue.size(), dw);
      end
      chain_hash  = SHA_H0;
      msg_bit_len = '0;
      fill_pos    = '0;
      messages_hashed++;
   endfunction

   function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("mismatch at cycle %0d: %s expected %h, got %h", cycle_count, what, want, got);
   endfunction

   // Present one item, hold it until accepted, then update the prediction
   task automatic push_item(input logic [7:0] b, input logic present, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_msg_byte        <= b;
      req_byte_present    <= present;
      req_last_of_message <= last;
      do @(posedge clock); while (!req_ready);
      if (present || last) items_sent++;
      sha_absorb_item(b, present, last);
   endtask

   // Empty messages, with an ignored empty item ahead of the first one
   task automatic test_empty_message();
      push_item(8'($urandom), 1'b0, 1'b0);
      push_item(8'($urandom), 1'b0, 1'b1);
      push_item(8'hff, 1'b0, 1'b1);
   endtask

   // Short message ending on a byte-carrying item
   task automatic test_abc();
      push_item(8'h61, 1'b1, 1'b0);
      push_item(8'h62, 1'b1, 1'b0);
      push_item(8'h63, 1'b1, 1'b1);
   endtask

   // Byte extremes, an ignored item mid-message, end-only item after bytes
   task automatic test_byte_extremes();
      push_item(8'h00, 1'b1, 1'b0);
      push_item(8'hff, 1'b1, 1'b0);
      push_item(8'h55, 1'b0, 1'b0);
      push_item(PAD_BYTE, 1'b1, 1'b0);
      push_item(8'haa, 1'b1, 1'b0);
      push_item(8'h00, 1'b0, 1'b1);
      push_item(8'h00, 1'b1, 1'b1);
      push_item(8'hff, 1'b1, 1'b1);
   endtask

   // Random messages, weighted toward the padding boundaries (55/56, 64)
   // The 2^64-bit length wrap is far beyond any simulated message.
   task automatic test_random_messages(input int sender_pct, input int receiver_pct,
                                       input int item_budget);
      int first_item, first_msg, len;
      logic end_only;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      first_item    = items_sent;
      first_msg     = messages_hashed;
      while (items_sent - first_item < item_budget || messages_hashed - first_msg < 4) begin
         case ($urandom_range(15))
            0, 1, 2, 3, 4, 5: len = $urandom_range(12, 1);
            6:                len = 0;
            7:                len = $urandom_range(57, 54);
            8:                len = $urandom_range(65, 62);
            9:                len = $urandom_range(121, 118);
            10:               len = 128;
            default:          len = $urandom_range(40, 13);
         endcase
         end_only = (len == 0) || ($urandom_range(3) == 0);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(11) == 0) push_item(8'($urandom), 1'b0, 1'b0);
            push_item(8'($urandom), 1'b1, !end_only && (i == len - 1));
         end
         if (end_only) push_item(8'($urandom), 1'b0, 1'b1);
      end
   endtask

   // Result side: random back-pressure and in-order field compare
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         words_checked++;
         if (digest_queue.size() == 0) begin
            flag_mismatch("unexpected digest word", '0, rsp_digest_word);
         end else begin
            oldest = digest_queue.pop_front();
            if (rsp_digest_word !== oldest.word)
               flag_mismatch($sformatf("word %0d value", oldest.index),
                             oldest.word, rsp_digest_word);
            if (rsp_word_index !== oldest.index)
               flag_mismatch("word_index", 32'(oldest.index), 32'(rsp_word_index));
            if (rsp_last_word !== oldest.last)
               flag_mismatch($sformatf("word %0d last_word", oldest.index),
                             32'(oldest.last), 32'(rsp_last_word));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout with %0d digest words outstanding", digest_queue.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_message();
      test_abc();
      test_byte_extremes();
      test_random_messages(38, 68, 117);
      test_random_messages(68, 38, 117);
      test_random_messages(0, 0, 117);
      req_valid <= 1'b0;

      while (digest_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Hashed %0d messages (%0d bytes in %0d items), checked %0d digest words",
               messages_hashed, bytes_hashed, items_sent, words_checked);
      $display("Mismatches: %0d, digest words still outstanding: %0d",
               mismatch_count, digest_queue.size());
      if (mismatch_count == 0 && digest_queue.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
